/* design/otl_pkg.sv */
// Shared types, constants and byte decode functions for the operator token lexer.
package otl_pkg;

  localparam int CounterBitsDef = 24;
  localparam int FieldW         = 24;
  localparam int KindW          = 5;

  // Source characters
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_LESS    = 8'h3C;
  localparam logic [7:0] CH_GREATER = 8'h3E;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // Token kinds
  localparam logic [KindW-1:0] KIND_LPAREN        = 5'd0;
  localparam logic [KindW-1:0] KIND_RPAREN        = 5'd1;
  localparam logic [KindW-1:0] KIND_LBRACE        = 5'd2;
  localparam logic [KindW-1:0] KIND_RBRACE        = 5'd3;
  localparam logic [KindW-1:0] KIND_COMMA         = 5'd4;
  localparam logic [KindW-1:0] KIND_DOT           = 5'd5;
  localparam logic [KindW-1:0] KIND_MINUS         = 5'd6;
  localparam logic [KindW-1:0] KIND_PLUS          = 5'd7;
  localparam logic [KindW-1:0] KIND_SEMI          = 5'd8;
  localparam logic [KindW-1:0] KIND_STAR          = 5'd9;
  localparam logic [KindW-1:0] KIND_BANG          = 5'd10;
  localparam logic [KindW-1:0] KIND_BANG_EQUAL    = 5'd11;
  localparam logic [KindW-1:0] KIND_EQUAL         = 5'd12;
  localparam logic [KindW-1:0] KIND_EQUAL_EQUAL   = 5'd13;
  localparam logic [KindW-1:0] KIND_LESS          = 5'd14;
  localparam logic [KindW-1:0] KIND_LESS_EQUAL    = 5'd15;
  localparam logic [KindW-1:0] KIND_GREATER       = 5'd16;
  localparam logic [KindW-1:0] KIND_GREATER_EQUAL = 5'd17;
  localparam logic [KindW-1:0] KIND_SLASH         = 5'd18;
  localparam logic [KindW-1:0] KIND_EOF           = 5'd19;
  localparam logic [KindW-1:0] KIND_ERROR         = 5'd20;

  localparam logic [1:0] LEN_NONE = 2'd0;
  localparam logic [1:0] LEN_ONE  = 2'd1;
  localparam logic [1:0] LEN_TWO  = 2'd2;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_BANG    = 3'd1,
    MODE_EQUAL   = 3'd2,
    MODE_LESS    = 3'd3,
    MODE_GREATER = 3'd4,
    MODE_SLASH   = 3'd5,
    MODE_COMMENT = 3'd6
  } otl_mode_t;

  typedef enum logic [2:0] {
    CLS_SINGLE,
    CLS_OP,
    CLS_SLASH,
    CLS_BLANK,
    CLS_NEWLINE,
    CLS_OTHER
  } otl_class_t;

  typedef struct packed {
    logic [KindW-1:0]  token_kind;
    logic [FieldW-1:0] lexeme_start;
    logic [1:0]        lexeme_length;
    logic [FieldW-1:0] line_number;
    logic              last;
  } otl_token_t;

  function automatic otl_class_t byte_class(input logic [7:0] c);
    otl_class_t cls;
    case (c) inside
      CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_COMMA,
      CH_DOT, CH_MINUS, CH_PLUS, CH_SEMI, CH_STAR:   cls = CLS_SINGLE;
      CH_BANG, CH_EQUAL, CH_LESS, CH_GREATER:        cls = CLS_OP;
      CH_SLASH:                                      cls = CLS_SLASH;
      CH_SPACE, CH_CR, CH_TAB:                       cls = CLS_BLANK;
      CH_NEWLINE:                                    cls = CLS_NEWLINE;
      default:                                       cls = CLS_OTHER;
    endcase
    return cls;
  endfunction

  function automatic logic [KindW-1:0] single_kind(input logic [7:0] c);
    logic [KindW-1:0] k;
    case (c)
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_COMMA:  k = KIND_COMMA;
      CH_DOT:    k = KIND_DOT;
      CH_MINUS:  k = KIND_MINUS;
      CH_PLUS:   k = KIND_PLUS;
      CH_SEMI:   k = KIND_SEMI;
      default:   k = KIND_STAR;
    endcase
    return k;
  endfunction

  function automatic otl_mode_t op_mode(input logic [7:0] c);
    otl_mode_t m;
    case (c)
      CH_BANG:  m = MODE_BANG;
      CH_EQUAL: m = MODE_EQUAL;
      CH_LESS:  m = MODE_LESS;
      default:  m = MODE_GREATER;
    endcase
    return m;
  endfunction

  // One-byte kind of a pending operator; the two-byte kind is one above it
  function automatic logic [KindW-1:0] op_kind(input otl_mode_t m);
    logic [KindW-1:0] k;
    unique case (m)
      MODE_BANG:  k = KIND_BANG;
      MODE_EQUAL: k = KIND_EQUAL;
      MODE_LESS:  k = KIND_LESS;
      default:    k = KIND_GREATER;
    endcase
    return k;
  endfunction

endpackage

/* design/otl_if.sv */
// Stream interfaces for source bytes and result tokens.
interface otl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_source;

  modport source (output valid, output in_byte, output end_of_source, input ready);
  modport sink   (input valid, input in_byte, input end_of_source, output ready);
endinterface

interface otl_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [23:0] lexeme_start;
  logic [1:0]  lexeme_length;
  logic [23:0] line_number;
  logic        last;

  modport source (output valid, output token_kind, output lexeme_start,
                  output lexeme_length, output line_number, output last, input ready);
  modport sink   (input valid, input token_kind, input lexeme_start,
                  input lexeme_length, input line_number, input last, output ready);
endinterface

/* design/otl_scan.sv */
// One-byte scan step: next lexer state and up to two tokens.
module otl_scan
  import otl_pkg::*;
#(
  parameter int CNT_W = CounterBitsDef
) (
  input  otl_mode_t        mode,
  input  logic [CNT_W-1:0] line_cnt,
  input  logic [CNT_W-1:0] byte_off,
  input  logic [CNT_W-1:0] pend_start,
  input  logic [7:0]       c,
  input  logic             eos,
  output otl_mode_t        mode_nxt,
  output logic [CNT_W-1:0] line_cnt_nxt,
  output logic [CNT_W-1:0] byte_off_nxt,
  output logic [CNT_W-1:0] pend_start_nxt,
  output otl_token_t       tok [2],
  output logic [1:0]       n_tok
);

  otl_class_t       cls;
  logic             is_eq;
  logic             is_slash;
  logic             pend_op;
  logic             run_idle;
  logic [CNT_W-1:0] off_inc;
  logic [CNT_W-1:0] line_inc;
  logic             has_a;
  logic             has_b;
  otl_token_t       tok_a;
  otl_token_t       tok_b;

  assign cls      = byte_class(c);
  assign is_eq    = (c == CH_EQUAL);
  assign is_slash = (c == CH_SLASH);
  assign pend_op  = (mode == MODE_BANG) || (mode == MODE_EQUAL) ||
                    (mode == MODE_LESS) || (mode == MODE_GREATER);
  assign off_inc  = (byte_off == '1) ? byte_off : byte_off + CNT_W'(1);
  assign line_inc = (line_cnt == '1) ? line_cnt : line_cnt + CNT_W'(1);

  // Byte goes through the plain scan: idle, or a pending token not completed
  assign run_idle = !eos && (
                      (pend_op && !is_eq) ||
                      ((mode == MODE_SLASH) && !is_slash) ||
                      (!pend_op && (mode != MODE_SLASH) && (mode != MODE_COMMENT)));

  // Next state
  always_comb begin
    mode_nxt       = mode;
    line_cnt_nxt   = line_cnt;
    byte_off_nxt   = off_inc;
    pend_start_nxt = pend_start;
    if (eos) begin
      mode_nxt       = MODE_IDLE;
      line_cnt_nxt   = CNT_W'(1);
      byte_off_nxt   = '0;
      pend_start_nxt = '0;
    end else if (run_idle) begin
      mode_nxt = MODE_IDLE;
      case (cls)
        CLS_OP: begin
          mode_nxt       = op_mode(c);
          pend_start_nxt = byte_off;
        end
        CLS_SLASH: begin
          mode_nxt       = MODE_SLASH;
          pend_start_nxt = byte_off;
        end
        CLS_NEWLINE: line_cnt_nxt = line_inc;
        default: ;
      endcase
    end else begin
      unique case (mode)
        MODE_SLASH:   mode_nxt = MODE_COMMENT;
        MODE_COMMENT: begin
          if (c == CH_NEWLINE) begin
            mode_nxt     = MODE_IDLE;
            line_cnt_nxt = line_inc;
          end
        end
        default:      mode_nxt = MODE_IDLE;
      endcase
    end
  end

  // Tokens: A is a flushed or completed operator, B a scanned byte or end-of-file
  always_comb begin
    tok_a.token_kind    = KIND_SLASH;
    tok_a.lexeme_start  = FieldW'(pend_start);
    tok_a.lexeme_length = LEN_ONE;
    tok_a.line_number   = FieldW'(line_cnt);
    has_a               = 1'b0;
    if (pend_op) begin
      has_a = 1'b1;
      if (!eos && is_eq) begin
        tok_a.token_kind    = op_kind(mode) + KindW'(1);
        tok_a.lexeme_length = LEN_TWO;
      end else begin
        tok_a.token_kind = op_kind(mode);
      end
    end else if (mode == MODE_SLASH) begin
      has_a = eos || !is_slash;
    end

    tok_b.lexeme_start  = FieldW'(byte_off);
    tok_b.lexeme_length = LEN_ONE;
    tok_b.line_number   = FieldW'(line_cnt);
    tok_b.last          = 1'b1;
    tok_b.token_kind    = KIND_ERROR;
    has_b               = 1'b0;
    if (eos) begin
      has_b               = 1'b1;
      tok_b.token_kind    = KIND_EOF;
      tok_b.lexeme_length = LEN_NONE;
    end else if (run_idle) begin
      if (cls == CLS_SINGLE) begin
        has_b            = 1'b1;
        tok_b.token_kind = single_kind(c);
      end else if (cls == CLS_OTHER) begin
        has_b = 1'b1;
      end
    end
    tok_a.last = !has_b;

    tok[0] = has_a ? tok_a : tok_b;
    tok[1] = tok_b;
    n_tok  = {1'b0, has_a} + {1'b0, has_b};
  end

endmodule

/* design/operator_token_lexer.sv */
// Top level of the operator token lexer: input register, scan step, result queue.
// A byte transfer is caught in the input register, then scanned, and its tokens are
//   written to the two-entry result queue; the head token is driven on out_ch straight
//   from the queue register.
// Throughput: one byte per cycle while each byte gives at most one token and out_ch is ready;
//   a byte that gives two tokens holds the input until they fit in the queue's two slots.
// Reset (rst_n low, synchronous): mode idle, line 1, offset 0, both stages emptied,
//   input not ready while reset is low.
module operator_token_lexer
  import otl_pkg::*;
#(
  parameter int COUNTER_BITS = CounterBitsDef
) (
  input logic    clk,
  input logic    rst_n,
  otl_in_if.sink   in_ch,
  otl_out_if.source out_ch
);

  // Input register
  logic             in_v_r;
  logic [7:0]       in_byte_r;
  logic             in_eos_r;

  // Lexer state
  otl_mode_t         mode_r, mode_nxt;
  logic [COUNTER_BITS-1:0] line_r, line_nxt;
  logic [COUNTER_BITS-1:0] off_r, off_nxt;
  logic [COUNTER_BITS-1:0] pstart_r, pstart_nxt;

  // Result queue, head in slot 0
  otl_token_t q_r [2];
  otl_token_t q_nxt [2];
  logic [1:0] cnt_r, cnt_nxt;

  otl_token_t tok [2];
  logic [1:0] n_tok;
  logic       pop;
  logic [1:0] keep;
  logic       fire;

  otl_scan #(.CNT_W(COUNTER_BITS)) u_scan (
    .mode           (mode_r),
    .line_cnt       (line_r),
    .byte_off       (off_r),
    .pend_start     (pstart_r),
    .c              (in_byte_r),
    .eos            (in_eos_r),
    .mode_nxt       (mode_nxt),
    .line_cnt_nxt   (line_nxt),
    .byte_off_nxt   (off_nxt),
    .pend_start_nxt (pstart_nxt),
    .tok            (tok),
    .n_tok          (n_tok)
  );

  // Pop the head on an output transfer; scan the held byte only if its tokens fit
  assign pop  = (cnt_r != 2'd0) && out_ch.ready;
  assign keep = cnt_r - {1'b0, pop};
  assign fire = in_v_r && (({1'b0, keep} + {1'b0, n_tok}) <= 3'd2);

  // Take a new byte whenever the input register is empty or drains this cycle
  assign in_ch.ready = rst_n && (!in_v_r || fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  // Hold the payload until the byte is scanned
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.in_byte;
      in_eos_r  <= in_ch.end_of_source;
    end
  end

  // Advance the lexer state once per scanned byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      line_r   <= COUNTER_BITS'(1);
      off_r    <= '0;
      pstart_r <= '0;
    end else if (fire) begin
      mode_r   <= mode_nxt;
      line_r   <= line_nxt;
      off_r    <= off_nxt;
      pstart_r <= pstart_nxt;
    end
  end

  // Queue update: shift out the popped head, then append new tokens behind what stays
  always_comb begin
    q_nxt[0] = pop ? q_r[1] : q_r[0];
    q_nxt[1] = q_r[1];
    cnt_nxt  = keep;
    if (fire) begin
      if (n_tok != 2'd0) begin
        q_nxt[keep[0]] = tok[0];
      end
      if (n_tok == 2'd2) begin
        q_nxt[1] = tok[1];
      end
      cnt_nxt = keep + n_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

  assign out_ch.valid         = (cnt_r != 2'd0);
  assign out_ch.token_kind    = q_r[0].token_kind;
  assign out_ch.lexeme_start  = q_r[0].lexeme_start;
  assign out_ch.lexeme_length = q_r[0].lexeme_length;
  assign out_ch.line_number   = q_r[0].line_number;
  assign out_ch.last          = q_r[0].last;

  // The queue never holds more than its two slots
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2)
    else $error("result queue count out of range");

  // End of source always produces at least the end-of-file token
  a_eos_token: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_eos_r |-> n_tok != 2'd0)
    else $error("end of source scanned without a token");

  // End of source returns the lexer to its reset state
  a_eos_reset: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_eos_r |=> mode_r == MODE_IDLE && line_r == COUNTER_BITS'(1) &&
                          off_r == '0)
    else $error("state not cleared after end of source");

  // Every scanned source byte moves the offset off zero
  a_off_adv: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !in_eos_r |=> off_r != '0)
    else $error("byte offset did not advance");

endmodule
